/* hdl/qcf_pkg.sv */
// shared types and constants for the quadratic curve flattener
package qcf_pkg;

   // field widths
   localparam int COORD_W    = 32;
   localparam int LINES_W    = 6;
   localparam int CAP_W      = 7;
   localparam int COUNT_W    = 7;
   localparam int MAX_LINES  = 50;

   // stream and register port widths
   localparam int REQ_DATA_W = 200;
   localparam int RSP_DATA_W = 72;
   localparam int CSR_ADDR_W = 1;
   localparam int CSR_DATA_W = 7;

   // register indexes
   localparam logic [CSR_ADDR_W-1:0] CSR_LINES    = 1'b0;
   localparam logic [CSR_ADDR_W-1:0] CSR_CAPACITY = 1'b1;

   // arithmetic widths: weights up to 2500, products of a 32-bit coordinate and a weight
   localparam int COEF_W     = 12;
   localparam int PROD_W     = COORD_W + COEF_W + 1;
   localparam int SUM_W      = PROD_W + 2;
   localparam int DIV_W      = SUM_W + 1;
   localparam int DIVISOR_W  = COEF_W + 1;

   // divider: four quotient bits per cycle
   localparam int DIV_BITS   = 4;
   localparam int DIV_STEPS  = DIV_W / DIV_BITS;
   localparam int DIV_CNT_W  = $clog2(DIV_STEPS);

   // what the output register takes on a load
   typedef enum logic [1:0] {
      EMIT_NONE,
      EMIT_A,
      EMIT_FAIL,
      EMIT_PT
   } emit_type;

   // controller to datapath
   typedef struct packed {
      logic                 load_op;
      logic                 div_start;
      emit_type             emit;
      logic [LINES_W-1:0]   n;
      logic [LINES_W-1:0]   i;
      logic [COUNT_W-1:0]   count;
      logic                 last;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic div_done;
   } sts_type;

endpackage

/* hdl/qcf_div.sv */
// signed floor divider by a positive narrow divisor, four quotient bits per cycle
module qcf_div (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   input  logic [qcf_pkg::DIV_W-1:0]       dividend,   // two's complement
   input  logic [qcf_pkg::DIVISOR_W-1:0]   divisor,
   output logic                            done,
   output logic [qcf_pkg::COORD_W-1:0]     quotient
);
   import qcf_pkg::*;

   logic                   busy_ff, busy_in;
   logic                   done_ff, done_in;
   logic [DIV_CNT_W-1:0]   cnt_ff, cnt_in;
   logic [DIV_W-1:0]       dq_ff, dq_in;
   logic [DIVISOR_W-1:0]   rem_ff, rem_in;
   logic [DIVISOR_W-1:0]   dvs_ff, dvs_in;
   logic                   neg_ff, neg_in;
   logic [DIV_W-1:0]       step_dq;
   logic [DIVISOR_W-1:0]   step_rem;
   logic [DIV_W-1:0]       q_up;
   logic [DIV_W-1:0]       q_res;

   // restoring steps: dividend shifts out the top, quotient bits shift in the bottom
   always_comb begin
      logic [DIVISOR_W:0] r2;
      step_dq  = dq_ff;
      step_rem = rem_ff;
      for (int k = 0; k < DIV_BITS; k++) begin
         r2      = {step_rem, step_dq[DIV_W-1]};
         step_dq = {step_dq[DIV_W-2:0], 1'b0};
         if (r2 >= {1'b0, dvs_ff}) begin
            r2         = r2 - {1'b0, dvs_ff};
            step_dq[0] = 1'b1;
         end
         step_rem = r2[DIVISOR_W-1:0];
      end
   end

   // load or iterate
   always_comb begin
      busy_in = busy_ff;
      done_in = done_ff;
      cnt_in  = cnt_ff;
      dq_in   = dq_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      neg_in  = neg_ff;
      if (start) begin
         neg_in  = dividend[DIV_W-1];
         dq_in   = dividend[DIV_W-1] ? (~dividend + DIV_W'(1)) : dividend;
         rem_in  = '0;
         dvs_in  = divisor;
         cnt_in  = '0;
         busy_in = 1'b1;
         done_in = 1'b0;
      end else if (busy_ff) begin
         dq_in  = step_dq;
         rem_in = step_rem;
         cnt_in = cnt_ff + DIV_CNT_W'(1);
         if (cnt_ff == DIV_CNT_W'(DIV_STEPS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   // working registers
   always_ff @(posedge clock) begin
      dq_ff  <= dq_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
      neg_ff <= neg_in;
   end

   // floor of a negative value: magnitude rounds up when a remainder is left
   assign q_up     = dq_ff + DIV_W'(rem_ff != '0);
   assign q_res    = neg_ff ? (~q_up + DIV_W'(1)) : dq_ff;
   assign quotient = q_res[COORD_W-1:0];
   assign done     = done_ff;

   a_start_clears_done: assert property (@(posedge clock) disable iff (reset)
      start |=> (busy_ff && !done_ff))
      else $error("divider did not start cleanly");

endmodule

/* hdl/qcf_dp.sv */
// datapath: operands, Bernstein weights, products, sums, dividers and output register
module qcf_dp (
   input  logic                          clock,
   input  logic                          reset,
   input  logic [qcf_pkg::COORD_W-1:0]   a_x,
   input  logic [qcf_pkg::COORD_W-1:0]   a_y,
   input  logic [qcf_pkg::COORD_W-1:0]   b_x,
   input  logic [qcf_pkg::COORD_W-1:0]   b_y,
   input  logic [qcf_pkg::COORD_W-1:0]   c_x,
   input  logic [qcf_pkg::COORD_W-1:0]   c_y,
   input  qcf_pkg::cmd_type              cmd,
   output qcf_pkg::sts_type              sts,
   output logic [qcf_pkg::COORD_W-1:0]   pt_x,
   output logic [qcf_pkg::COORD_W-1:0]   pt_y,
   output logic                          fits,
   output logic [qcf_pkg::COUNT_W-1:0]   count_after,
   output logic                          last
);
   import qcf_pkg::*;

   logic signed [COORD_W-1:0] ax_ff, ay_ff, bx_ff, by_ff, cx_ff, cy_ff;
   logic [LINES_W-1:0]        m;
   logic [COEF_W-1:0]         w0_ff, w1_ff, w2_ff, den_ff;
   logic signed [PROD_W-1:0]  px0_ff, px1_ff, px2_ff, py0_ff, py1_ff, py2_ff;
   logic signed [SUM_W-1:0]   sx_ff, sy_ff;
   logic [DIV_W-1:0]          tx_ff, ty_ff;
   logic [DIVISOR_W-1:0]      divisor;
   logic                      done_x, done_y;
   logic [COORD_W-1:0]        qx, qy;
   logic [COORD_W-1:0]        pt_x_ff, pt_y_ff;
   logic                      fits_ff, last_ff;
   logic [COUNT_W-1:0]        count_ff;

   // control points of the current curve
   always_ff @(posedge clock) begin
      if (cmd.load_op) begin
         ax_ff <= a_x;
         ay_ff <= a_y;
         bx_ff <= b_x;
         by_ff <= b_y;
         cx_ff <= c_x;
         cy_ff <= c_y;
      end
   end

   // weights (n-i)^2, 2i(n-i), i^2 and the common denominator n^2
   assign m = cmd.n - cmd.i;

   always_ff @(posedge clock) begin
      w0_ff  <= COEF_W'(m) * COEF_W'(m);
      w1_ff  <= (COEF_W'(cmd.i) * COEF_W'(m)) << 1;
      w2_ff  <= COEF_W'(cmd.i) * COEF_W'(cmd.i);
      den_ff <= COEF_W'(cmd.n) * COEF_W'(cmd.n);
   end

   // weighted control points
   always_ff @(posedge clock) begin
      px0_ff <= ax_ff * $signed({1'b0, w0_ff});
      px1_ff <= bx_ff * $signed({1'b0, w1_ff});
      px2_ff <= cx_ff * $signed({1'b0, w2_ff});
      py0_ff <= ay_ff * $signed({1'b0, w0_ff});
      py1_ff <= by_ff * $signed({1'b0, w1_ff});
      py2_ff <= cy_ff * $signed({1'b0, w2_ff});
   end

   // numerator
   always_ff @(posedge clock) begin
      sx_ff <= SUM_W'(px0_ff) + SUM_W'(px1_ff) + SUM_W'(px2_ff);
      sy_ff <= SUM_W'(py0_ff) + SUM_W'(py1_ff) + SUM_W'(py2_ff);
   end

   // round half up: floor((2*num + den) / (2*den))
   always_ff @(posedge clock) begin
      tx_ff <= {sx_ff, 1'b0} + DIV_W'(den_ff);
      ty_ff <= {sy_ff, 1'b0} + DIV_W'(den_ff);
   end

   assign divisor = {den_ff, 1'b0};

   qcf_div u_div_x (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .dividend (tx_ff),
      .divisor  (divisor),
      .done     (done_x),
      .quotient (qx)
   );

   qcf_div u_div_y (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .dividend (ty_ff),
      .divisor  (divisor),
      .done     (done_y),
      .quotient (qy)
   );

   assign sts.div_done = done_x & done_y;

   // output register
   always_ff @(posedge clock) begin
      case (cmd.emit)
         EMIT_A: begin
            pt_x_ff  <= ax_ff;
            pt_y_ff  <= ay_ff;
            fits_ff  <= 1'b1;
            count_ff <= cmd.count;
            last_ff  <= cmd.last;
         end
         EMIT_FAIL: begin
            pt_x_ff  <= '0;
            pt_y_ff  <= '0;
            fits_ff  <= 1'b0;
            count_ff <= cmd.count;
            last_ff  <= cmd.last;
         end
         EMIT_PT: begin
            pt_x_ff  <= qx;
            pt_y_ff  <= qy;
            fits_ff  <= 1'b1;
            count_ff <= cmd.count;
            last_ff  <= cmd.last;
         end
         default: begin
         end
      endcase
   end

   assign pt_x        = pt_x_ff;
   assign pt_y        = pt_y_ff;
   assign fits        = fits_ff;
   assign count_after = count_ff;
   assign last        = last_ff;

endmodule

/* hdl/qcf_ctrl.sv */
// controller: registers, capacity check and point sequencing
module qcf_ctrl (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   input  logic [qcf_pkg::COUNT_W-1:0]      start_count,
   input  logic                             csr_we,
   input  logic [qcf_pkg::CSR_ADDR_W-1:0]   csr_addr,
   input  logic [qcf_pkg::CSR_DATA_W-1:0]   csr_wdata,
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   output qcf_pkg::cmd_type                 cmd,
   input  qcf_pkg::sts_type                 sts
);
   import qcf_pkg::*;

   typedef enum logic [2:0] {
      S_IDLE,
      S_FIRST,
      S_COEF,
      S_PROD,
      S_SUM,
      S_BIAS,
      S_LOAD,
      S_DIV
   } state_type;

   state_type            state_ff, state_in;
   logic [LINES_W-1:0]   lines_ff, lines_in;
   logic [CAP_W-1:0]     cap_ff, cap_in;
   logic [LINES_W-1:0]   n_ff, n_in;
   logic [LINES_W-1:0]   i_ff, i_in;
   logic [COUNT_W-1:0]   start_ff, start_in;
   logic [COUNT_W-1:0]   cnt_ff, cnt_in;
   logic                 fail_ff, fail_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [LINES_W-1:0]   n_sat;
   logic                 out_free;
   logic                 req_accept;

   assign req_tready = (state_ff == S_IDLE);
   assign req_accept = req_tvalid && req_tready;
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign n_sat      = (lines_ff > LINES_W'(MAX_LINES)) ? LINES_W'(MAX_LINES) : lines_ff;

   // next state and commands
   always_comb begin
      state_in      = state_ff;
      lines_in      = lines_ff;
      cap_in        = cap_ff;
      n_in          = n_ff;
      i_in          = i_ff;
      start_in      = start_ff;
      cnt_in        = cnt_ff;
      fail_in       = fail_ff;
      cmd.load_op   = 1'b0;
      cmd.div_start = 1'b0;
      cmd.emit      = EMIT_NONE;
      cmd.n         = n_ff;
      cmd.i         = i_ff;
      cmd.count     = cnt_ff;
      cmd.last      = 1'b0;

      // register writes
      if (csr_we) begin
         case (csr_addr)
            CSR_LINES:    lines_in = csr_wdata[LINES_W-1:0];
            CSR_CAPACITY: cap_in   = csr_wdata[CAP_W-1:0];
            default: begin
            end
         endcase
      end

      case (state_ff)
         S_IDLE: begin
            if (req_accept) begin
               cmd.load_op = 1'b1;
               n_in        = n_sat;
               start_in    = start_count;
               fail_in     = ({1'b0, start_count} + {2'b0, n_sat}) >= {1'b0, cap_ff};
               state_in    = S_FIRST;
            end
         end
         // point A, or the single failure result
         S_FIRST: begin
            if (out_free) begin
               cmd.emit  = fail_ff ? EMIT_FAIL : EMIT_A;
               cmd.count = fail_ff ? start_ff : COUNT_W'(start_ff + COUNT_W'(1));
               cmd.last  = fail_ff || (n_ff <= LINES_W'(1));
               cnt_in    = COUNT_W'(start_ff + COUNT_W'(1));
               i_in      = LINES_W'(1);
               state_in  = cmd.last ? S_IDLE : S_COEF;
            end
         end
         S_COEF: state_in = S_PROD;
         S_PROD: state_in = S_SUM;
         S_SUM:  state_in = S_BIAS;
         S_BIAS: state_in = S_LOAD;
         S_LOAD: begin
            cmd.div_start = 1'b1;
            state_in      = S_DIV;
         end
         // interior point once both quotients are in
         S_DIV: begin
            if (sts.div_done && out_free) begin
               cmd.emit  = EMIT_PT;
               cmd.count = COUNT_W'(cnt_ff + COUNT_W'(1));
               cmd.last  = (LINES_W'(i_ff + LINES_W'(1)) == n_ff);
               cnt_in    = COUNT_W'(cnt_ff + COUNT_W'(1));
               i_in      = LINES_W'(i_ff + LINES_W'(1));
               state_in  = cmd.last ? S_IDLE : S_COEF;
            end
         end
         default: state_in = S_IDLE;
      endcase

      rsp_valid_in = (cmd.emit != EMIT_NONE) ? 1'b1 : (rsp_valid_ff && !rsp_tready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         lines_ff     <= LINES_W'(8);
         cap_ff       <= CAP_W'(54);
         n_ff         <= '0;
         i_ff         <= '0;
         start_ff     <= '0;
         cnt_ff       <= '0;
         fail_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         lines_ff     <= lines_in;
         cap_ff       <= cap_in;
         n_ff         <= n_in;
         i_ff         <= i_in;
         start_ff     <= start_in;
         cnt_ff       <= cnt_in;
         fail_ff      <= fail_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;

   a_emit_needs_slot: assert property (@(posedge clock) disable iff (reset)
      (cmd.emit != EMIT_NONE) |-> out_free)
      else $error("output register overwritten while a response waits");

   a_interior_index: assert property (@(posedge clock) disable iff (reset)
      (state_ff != S_IDLE && state_ff != S_FIRST) |-> (i_ff != '0 && i_ff < n_ff))
      else $error("interior point index out of range");

   a_last_goes_idle: assert property (@(posedge clock) disable iff (reset)
      (cmd.emit != EMIT_NONE && cmd.last) |=> (state_ff == S_IDLE))
      else $error("curve not closed after its last response");

endmodule

/* hdl/quadratic_curve_flattener_unit.sv */
// top level of the quadratic curve flattener
// Each request carries the control points A, B, C (signed Q16.16) and the
// destination store count. If the count plus n = min(lines_per_curve, 50) is
// not below store_capacity, one response with tuser = 0 comes back; otherwise
// the block returns A followed by the n-1 interior points of the quadratic
// curve, each rounded to nearest with halves up, the last one flagged by
// tlast. Point A (or the failure response) enters the output register once
// the request is taken and the register is free; each interior point then
// passes the weight, product, sum and bias registers and the divider, which
// retires four quotient bits per cycle. A new request is taken once the last
// response of the previous one is in the output register.
module quadratic_curve_flattener_unit (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // a_x, a_y, b_x, b_y, c_x, c_y, start_count, zero pad
   input  logic [qcf_pkg::REQ_DATA_W-1:0]      req_tdata,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // pt_x, pt_y, count_after, zero pad
   output logic [qcf_pkg::RSP_DATA_W-1:0]      rsp_tdata,
   // fits
   output logic                                rsp_tuser,
   output logic                                rsp_tlast,
   input  logic                                csr_we,
   input  logic [qcf_pkg::CSR_ADDR_W-1:0]      csr_addr,
   input  logic [qcf_pkg::CSR_DATA_W-1:0]      csr_wdata
);
   import qcf_pkg::*;

   cmd_type              cmd;
   sts_type              sts;
   logic [COORD_W-1:0]   pt_x, pt_y;
   logic [COUNT_W-1:0]   count_after;

   qcf_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .start_count (req_tdata[6*COORD_W +: COUNT_W]),
      .csr_we      (csr_we),
      .csr_addr    (csr_addr),
      .csr_wdata   (csr_wdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .cmd         (cmd),
      .sts         (sts)
   );

   qcf_dp u_dp (
      .clock       (clock),
      .reset       (reset),
      .a_x         (req_tdata[0*COORD_W +: COORD_W]),
      .a_y         (req_tdata[1*COORD_W +: COORD_W]),
      .b_x         (req_tdata[2*COORD_W +: COORD_W]),
      .b_y         (req_tdata[3*COORD_W +: COORD_W]),
      .c_x         (req_tdata[4*COORD_W +: COORD_W]),
      .c_y         (req_tdata[5*COORD_W +: COORD_W]),
      .cmd         (cmd),
      .sts         (sts),
      .pt_x        (pt_x),
      .pt_y        (pt_y),
      .fits        (rsp_tuser),
      .count_after (count_after),
      .last        (rsp_tlast)
   );

   // response packing, low field first
   assign rsp_tdata = {1'b0, count_after, pt_y, pt_x};

endmodule

/* dv/quadratic_curve_flattener_unit_tb.sv */
// self-checking testbench for the quadratic curve flattener unit
module quadratic_curve_flattener_unit_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import qcf_pkg::*;

   localparam logic [COORD_W-1:0] COORD_MAX = 32'h7FFF_FFFF;
   localparam logic [COORD_W-1:0] COORD_MIN = 32'h8000_0000;
   localparam logic [COORD_W-1:0] COORD_NEG1 = 32'hFFFF_FFFF;

   // one curve request: control points and the store count
   typedef struct packed {
      logic signed [COORD_W-1:0] a_x, a_y, b_x, b_y, c_x, c_y;
      logic [COUNT_W-1:0]        start_count;
   } curve_type;

   // one generated point as seen on the response stream
   typedef struct packed {
      logic signed [COORD_W-1:0] pt_x, pt_y;
      logic                      fits;
      logic [COUNT_W-1:0]        count_after;
      logic                      is_last;
   } point_type;

   // expected points of every accepted curve, in order
   class curve_point_tracker;
      point_type          pending_points[$];
      logic [LINES_W-1:0] lines_per_curve;
      logic [CAP_W-1:0]   store_capacity;
      int                 mismatches;
      int                 points_seen;
      int                 curves_seen;
      int                 overflows_seen;

      function new();
         lines_per_curve = 8;
         store_capacity  = 54;
      endfunction

      function void write_reg(logic [CSR_ADDR_W-1:0] idx, logic [CSR_DATA_W-1:0] value);
         if (idx == CSR_LINES) begin
            lines_per_curve = value[LINES_W-1:0];
         end else begin
            store_capacity = value[CAP_W-1:0];
         end
      endfunction

      // line count after saturation at MAX_LINES
      function int lines_used();
         return (lines_per_curve > MAX_LINES) ? MAX_LINES : int'(lines_per_curve);
      endfunction

      // floor(num/den + 1/2), den > 0
      function longint round_half_up(longint num, longint den);
         longint q;
         longint d2;
         q  = 2 * num + den;
         d2 = 2 * den;
         if (q >= 0) return q / d2;
         return -((-q + d2 - 1) / d2);
      endfunction

      // interior coordinate i of n on the quadratic curve
      function logic [COORD_W-1:0] curve_coord(longint a, longint b, longint c, int n, int i);
         longint m;
         longint k;
         longint num;
         longint res;
         m   = n - i;
         k   = i;
         num = m * m * a + 2 * k * m * b + k * k * c;
         res = round_half_up(num, longint'(n) * longint'(n));
         return res[COORD_W-1:0];
      endfunction

      function void predict_curve(curve_type r);
         int        n;
         point_type p;
         n = lines_used();
         curves_seen++;
         // store would overflow: a single failure response
         if (int'(r.start_count) + n >= int'(store_capacity)) begin
            p             = '0;
            p.count_after = r.start_count;
            p.is_last     = 1'b1;
            pending_points.push_back(p);
            overflows_seen++;
            return;
         end
         // point a first, then the interior points
         for (int k = 0; k < ((n == 0) ? 1 : n); k++) begin
            if (k == 0) begin
               p.pt_x = r.a_x;
               p.pt_y = r.a_y;
            end else begin
               p.pt_x = curve_coord($signed(r.a_x), $signed(r.b_x), $signed(r.c_x), n, k);
               p.pt_y = curve_coord($signed(r.a_y), $signed(r.b_y), $signed(r.c_y), n, k);
            end
            p.fits        = 1'b1;
            p.count_after = COUNT_W'(int'(r.start_count) + k + 1);
            p.is_last     = (n <= 1) ? 1'b1 : (k + 1 == n);
            pending_points.push_back(p);
         end
      endfunction

      function void check_point(point_type got);
         point_type want;
         points_seen++;
         if (pending_points.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("%0t: unexpected point x=%h y=%h fits=%b count=%0d last=%b", $realtime,
                        got.pt_x, got.pt_y, got.fits, got.count_after, got.is_last);
            return;
         end
         want = pending_points.pop_front();
         if (got.pt_x !== want.pt_x || got.pt_y !== want.pt_y || got.fits !== want.fits ||
             got.count_after !== want.count_after || got.is_last !== want.is_last) begin
            mismatches++;
            if (mismatches <= 10) begin
               $display("%0t: point mismatch", $realtime);
               $display("   expected x=%h y=%h fits=%b count=%0d last=%b",
                        want.pt_x, want.pt_y, want.fits, want.count_after, want.is_last);
               $display("   actual   x=%h y=%h fits=%b count=%0d last=%b",
                        got.pt_x, got.pt_y, got.fits, got.count_after, got.is_last);
            end
         end
      endfunction
   endclass

   logic                  clock;
   logic                  reset;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata;
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  rsp_tuser;
   logic                  rsp_tlast;
   logic                  csr_we;
   logic [CSR_ADDR_W-1:0] csr_addr;
   logic [CSR_DATA_W-1:0] csr_wdata;

   curve_point_tracker    tracker;
   bit                    calm;
   bit                    hold_rsp_req;
   int                    holds_done;
   int                    settings_used;

   quadratic_curve_flattener_unit i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   // clock
   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // run limit
   initial begin
      #100ms;
      $display("quadratic_curve_flattener_unit regression: fail");
      $finish;
   end

   function automatic curve_type make_curve(logic [COORD_W-1:0] ax, logic [COORD_W-1:0] ay,
                                            logic [COORD_W-1:0] bx, logic [COORD_W-1:0] by,
                                            logic [COORD_W-1:0] cx, logic [COORD_W-1:0] cy,
                                            logic [COUNT_W-1:0] start);
      curve_type r;
      r.a_x = ax;
      r.a_y = ay;
      r.b_x = bx;
      r.b_y = by;
      r.c_x = cx;
      r.c_y = cy;
      r.start_count = start;
      return r;
   endfunction

   // mix of full range, tiny values, extremes and whole or exact-half values
   function automatic logic [COORD_W-1:0] random_coord();
      int sel;
      sel = $urandom_range(0, 6);
      case (sel)
         0, 1, 2: return $urandom;
         3: return COORD_W'($urandom_range(0, 511)) - COORD_W'(256);
         4: return $urandom & 32'hFFFF_8000;
         5: return $urandom_range(0, 1) ? COORD_MAX : COORD_MIN;
         default: return $urandom_range(0, 1) ? COORD_NEG1 : '0;
      endcase
   endfunction

   function automatic curve_type random_curve();
      curve_type r;
      int        n;
      int        cap;
      n   = tracker.lines_used();
      cap = int'(tracker.store_capacity);
      r   = make_curve(random_coord(), random_coord(), random_coord(), random_coord(),
                       random_coord(), random_coord(), '0);
      // mostly counts that leave room in the store
      if (cap > n && $urandom_range(0, 3) != 0)
         r.start_count = COUNT_W'($urandom_range(0, cap - n - 1));
      else
         r.start_count = COUNT_W'($urandom_range(0, 127));
      return r;
   endfunction

   // offer one request, return at the edge that accepts it
   task automatic send_curve(curve_type r);
      if (!calm && $urandom_range(0, 3) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 14)) @(posedge clock);
      end
      req_tdata  <= {1'b0, r.start_count, r.c_y, r.c_x, r.b_y, r.b_x, r.a_y, r.a_x};
      req_tvalid <= 1'b1;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      tracker.predict_curve(r);
   endtask

   task automatic send_random(int count);
      repeat (count) send_curve(random_curve());
   endtask

   // stop offering and wait until every expected point is back
   task automatic settle();
      req_tvalid <= 1'b0;
      while (tracker.pending_points.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
   endtask

   task automatic configure(int lines, int cap);
      settle();
      csr_we    <= 1'b1;
      csr_addr  <= CSR_LINES;
      csr_wdata <= CSR_DATA_W'(lines);
      @(posedge clock);
      tracker.write_reg(CSR_LINES, CSR_DATA_W'(lines));
      csr_addr  <= CSR_CAPACITY;
      csr_wdata <= CSR_DATA_W'(cap);
      @(posedge clock);
      tracker.write_reg(CSR_CAPACITY, CSR_DATA_W'(cap));
      csr_we <= 1'b0;
      settings_used++;
   endtask

   // response side: check accepted points and drive tready
   initial begin : rsp_side
      int        stall_left;
      int        hold_left;
      int        mode_left;
      bit        choppy;
      logic      next_ready;
      point_type got;
      stall_left = 0;
      hold_left  = 0;
      mode_left  = 0;
      choppy     = 1'b1;
      rsp_tready <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_tvalid && rsp_tready) begin
            got.pt_x        = rsp_tdata[COORD_W-1:0];
            got.pt_y        = rsp_tdata[2*COORD_W-1:COORD_W];
            got.count_after = rsp_tdata[2*COORD_W+COUNT_W-1:2*COORD_W];
            got.fits        = rsp_tuser;
            got.is_last     = rsp_tlast;
            tracker.check_point(got);
         end
         if (hold_rsp_req) begin
            hold_rsp_req = 1'b0;
            hold_left    = 300;
            holds_done++;
         end
         // alternate between choppy and smooth stretches
         if (mode_left == 0) begin
            choppy    = ($urandom_range(0, 2) != 0);
            mode_left = $urandom_range(20, 120);
         end else begin
            mode_left--;
         end
         if (hold_left > 0) begin
            hold_left--;
            next_ready = 1'b0;
         end else if (stall_left > 0) begin
            stall_left--;
            next_ready = 1'b0;
         end else if (choppy && !calm && $urandom_range(0, 5) == 0) begin
            stall_left = $urandom_range(1, 14) - 1;
            next_ready = 1'b0;
         end else begin
            next_ready = 1'b1;
         end
         rsp_tready <= next_ready;
      end
   end

   // request side and run control
   initial begin : stimulus
      tracker      = new();
      calm         = 1'b0;
      hold_rsp_req = 1'b0;
      reset      <= 1'b1;
      req_tvalid <= 1'b0;
      req_tdata  <= '0;
      csr_we     <= 1'b0;
      csr_addr   <= CSR_LINES;
      csr_wdata  <= '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset settings: eight lines, capacity 54
      send_curve(make_curve('0, '0, '0, '0, '0, '0, 7'd0));
      send_curve(make_curve(COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX,
                            7'd45));
      send_curve(make_curve(COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN,
                            7'd0));
      send_curve(make_curve(COORD_MAX, COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX, COORD_MIN,
                            7'd10));
      send_curve(make_curve(COORD_MIN, COORD_MAX, COORD_MAX, COORD_MIN, COORD_MIN, COORD_MAX,
                            7'd20));
      // exact halves: +0.5 goes up, -0.5 goes up to zero
      send_curve(make_curve('0, '0, '0, '0, 32'd32, -32'sd32, 7'd3));
      send_curve(make_curve(COORD_NEG1, 32'd1, 32'd1, COORD_NEG1, COORD_NEG1, 32'd1, 7'd1));
      // count plus lines equal to capacity, and beyond
      send_curve(make_curve(32'h1234_5678, 32'h8765_4321, '1, '1, '1, '1, 7'd46));
      send_curve(make_curve(COORD_MAX, COORD_MIN, '1, '0, '1, '0, 7'd127));
      send_curve(make_curve(32'd5, 32'd6, 32'd7, 32'd8, 32'd9, 32'd10, 7'd64));
      send_random(40);

      // zero lines: point a alone, then a count at capacity that overflows
      configure(0, 1);
      send_curve(make_curve(COORD_MAX, COORD_MIN, '0, '0, '0, '0, 7'd0));
      send_curve(make_curve(COORD_MAX, COORD_MIN, '0, '0, '0, '0, 7'd1));
      send_random(20);

      // line count above the limit saturates
      configure(63, 127);
      send_curve(make_curve(COORD_MAX, COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX, COORD_MIN,
                            7'd0));
      send_curve(make_curve(COORD_MIN, COORD_MAX, COORD_MAX, COORD_MIN, COORD_MIN, COORD_MAX,
                            7'd76));
      send_curve(make_curve('1, '1, '1, '1, '1, '1, 7'd77));
      send_random(6);

      // capacity zero: everything overflows
      configure(1, 0);
      send_curve(make_curve(32'd1, 32'd2, 32'd3, 32'd4, 32'd5, 32'd6, 7'd0));
      send_random(8);

      configure(1, 64);
      send_random(20);

      // receiver holds off while requests keep coming
      configure(2, 127);
      send_random(10);
      hold_rsp_req = 1'b1;
      send_random(15);

      configure(50, 64);
      send_random(8);

      configure(13, 40);
      send_random(20);
      // sender waits for every point before going on
      settle();
      send_random(20);

      configure(31, 100);
      send_random(20);

      // last part without idling
      configure(7, 90);
      calm = 1'b1;
      send_random(30);
      settle();

      if (tracker.pending_points.size() != 0) tracker.mismatches++;
      $display("covered %0d curves (%0d overflowing) over %0d register settings",
               tracker.curves_seen, tracker.overflows_seen, settings_used + 1);
      $display("checked %0d points, %0d long receiver hold-offs, %0d mismatches",
               tracker.points_seen, holds_done, tracker.mismatches);
      if (tracker.mismatches == 0) begin
         $display("quadratic_curve_flattener_unit regression: pass");
      end else begin
         $display("quadratic_curve_flattener_unit regression: fail");
      end
      $finish;
   end

endmodule
